>>> src/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit page allocator.
// No dependencies; used by bffa_scan and bitmap_first_fit_page_allocator.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  localparam int OP_W     = 2;
  localparam int PN_W     = 12;
  localparam int LEN_W    = 13;
  localparam int ADDR_W   = 24;
  localparam int PG_W     = 14;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 6;
  localparam int WW       = PG_W - POS_W;
  localparam int PG_SHIFT = 12;
  localparam int CNT_MAX  = 8191;

  localparam logic [LEN_W-1:0] PAGE_COUNT_RST = 13'd4096;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  typedef struct packed {
    logic             hit;
    logic             hit_fresh;
    logic [POS_W-1:0] hit_h;
    logic             any_used;
    logic [POS_W-1:0] last_h;
  } scan_res_t;

endpackage

`default_nettype wire

>>> src/bffa_scan.sv
// Evaluates one 64-page bitmap word for the first-fit run search.
// Depends on bffa_pkg for widths and the scan_res_t result struct.
`timescale 1ns / 1ps
`default_nettype none

module bffa_scan (
  input  logic [bffa_pkg::WORD_W-1:0] used_word,
  input  logic [bffa_pkg::LEN_W-1:0]  carry,
  input  logic [bffa_pkg::LEN_W-1:0]  run_len,
  output bffa_pkg::scan_res_t         res
);
  import bffa_pkg::*;

  localparam int LVL = POS_W;

  logic [WORD_W-1:0] hv [0:LVL];
  logic [POS_W-1:0]  hp [0:LVL][WORD_W];
  logic [POS_W-1:0]  gap [WORD_W];
  logic [WORD_W-1:0] match;
  logic [LEN_W-1:0]  tail_pos;

  // highest used position at or below each bit: prefix over log levels
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      hv[0][i] = used_word[i];
      hp[0][i] = POS_W'(i);
    end
    for (int k = 0; k < LVL; k++) begin
      for (int i = 0; i < WORD_W; i++) begin
        hv[k+1][i] = hv[k][i];
        hp[k+1][i] = hp[k][i];
      end
      for (int i = (1 << k); i < WORD_W; i++) begin
        if (!hv[k][i]) begin
          hv[k+1][i] = hv[k][i-(1<<k)];
          hp[k+1][i] = hp[k][i-(1<<k)];
        end
      end
    end
  end

  always_comb begin
    tail_pos = run_len - carry - LEN_W'(1);
    for (int i = 0; i < WORD_W; i++) begin
      gap[i] = POS_W'(i) - hp[LVL][i];
      match[i] = hv[LVL][i] ? (run_len == LEN_W'(gap[i])) : (tail_pos == LEN_W'(i));
    end
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.hit       = 1'b1;
        res.hit_fresh = hv[LVL][i];
        res.hit_h     = hp[LVL][i];
      end
    end
    res.any_used = hv[LVL][WORD_W-1];
    res.last_h   = hp[LVL][WORD_W-1];
  end

endmodule

`default_nettype wire

>>> src/bitmap_first_fit_page_allocator.sv
// Bitmap first-fit page allocator: top level with the bitmap memory and sequencer.
// Depends on bffa_pkg and bffa_scan.
`timescale 1ns / 1ps
`default_nettype none

// The used/free bitmap sits in a one-port-read, one-port-write memory of 64-bit
// words, one bit per 4 KiB page. After reset the block sweeps the memory to zero,
// one word a cycle, clearing all ceil(MAX_PAGES/64) words (64 by default) with in_stall high.
// One request is handled at a time. An allocate reads the words from page 0 up,
// one per cycle, and stops at the word where the first fitting run ends, then
// does a read-modify-write pass over the words the run spans. Free and reserve
// run only that pass. A new result waits in the response state while the
// previous result is still held by out_stall.
// The limit is min(page_count, MAX_PAGES); pages at or above it are left alone.
module bitmap_first_fit_page_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [bffa_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bffa_pkg::OP_W-1:0]     op,
  input  logic [bffa_pkg::PN_W-1:0]     page_number,
  input  logic [bffa_pkg::LEN_W-1:0]    run_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bffa_pkg::ADDR_W-1:0]   grant_addr,
  output logic                          ok
);
  import bffa_pkg::*;

  localparam int NW      = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WAW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int LIM_CAP = (MAX_PAGES > CNT_MAX) ? CNT_MAX : MAX_PAGES;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]        state;
  logic [WAW-1:0]    clr_cnt;
  logic [LEN_W-1:0]  page_count;
  logic [PG_W-1:0]   lim;

  logic [WORD_W-1:0] mem [NW];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [WAW-1:0]    mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic              is_set;
  logic [LEN_W-1:0]  run_len;
  logic [LEN_W-1:0]  carry;
  logic [PG_W-1:0]   start;
  logic [PG_W-1:0]   lo;
  logic [PG_W-1:0]   hi;
  logic [WW-1:0]     rd_word;
  logic [WW-1:0]     ev_word;
  logic [WW-1:0]     last_word;
  logic              ev_valid;
  logic [ADDR_W-1:0] res_addr;
  logic              res_ok;

  logic [PG_W-1:0]   base;
  logic [WORD_W-1:0] avail;
  logic [WORD_W-1:0] mk;
  logic [WORD_W-1:0] used_word;
  logic [WORD_W-1:0] wdata_mark;
  scan_res_t         scan;
  logic [PG_W-1:0]   hit_start;
  logic [PG_W-1:0]   hit_end;
  logic [PG_W-1:0]   pn_pg;
  logic [PG_W-1:0]   end_pg;
  logic [PG_W-1:0]   hi_fr;
  logic              accept;
  logic              out_load;

  assign lim = ({1'b0, page_count} > PG_W'(LIM_CAP)) ? PG_W'(LIM_CAP)
                                                     : PG_W'(page_count);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_RESP) && (!out_valid || !out_stall);

  assign base = {ev_word, POS_W'(0)};

  always_comb begin
    for (int p = 0; p < WORD_W; p++) begin
      avail[p] = (base + PG_W'(p)) < lim;
      mk[p]    = ((base + PG_W'(p)) >= lo) && ((base + PG_W'(p)) < hi);
    end
  end

  assign used_word  = rdata | ~avail;
  assign wdata_mark = is_set ? (rdata | mk) : (rdata & ~mk);

  bffa_scan u_scan (
    .used_word (used_word),
    .carry     (carry),
    .run_len   (run_len),
    .res       (scan)
  );

  assign hit_start = scan.hit_fresh ? (base + PG_W'(scan.hit_h) + PG_W'(1)) : start;
  assign hit_end   = hit_start + PG_W'(run_len);

  assign pn_pg  = PG_W'(page_number);
  assign end_pg = pn_pg + PG_W'(run_length);
  assign hi_fr  = (end_pg < lim) ? end_pg : lim;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = WAW'(ev_word);
    mem_wdata = wdata_mark;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_MARK: begin
        mem_we = ev_valid;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[WAW'(rd_word)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= PAGE_COUNT_RST;
    end else if (cfg_wen) begin
      page_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + WAW'(1);
          if (clr_cnt == WAW'(NW - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            ev_valid <= 1'b0;
            res_addr <= '0;
            res_ok   <= 1'b0;
            case (op)
              OP_ALLOC: begin
                is_set    <= 1'b1;
                run_len   <= run_length;
                carry     <= '0;
                start     <= '0;
                rd_word   <= '0;
                last_word <= WW'((lim - PG_W'(1)) >> POS_W);
                if (run_length == '0 || lim == '0) begin
                  state <= ST_RESP;
                end else begin
                  state <= ST_SCAN;
                end
              end
              OP_FREE, OP_RESERVE: begin
                is_set    <= (op == OP_RESERVE);
                res_addr  <= {page_number, PG_SHIFT'(0)};
                res_ok    <= 1'b1;
                lo        <= pn_pg;
                hi        <= hi_fr;
                rd_word   <= WW'(pn_pg >> POS_W);
                last_word <= WW'((hi_fr - PG_W'(1)) >> POS_W);
                if (pn_pg >= hi_fr) begin
                  state <= ST_RESP;
                end else begin
                  state <= ST_MARK;
                end
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          ev_word <= rd_word;
          if (ev_valid && scan.hit) begin
            lo        <= hit_start;
            hi        <= hit_end;
            res_addr  <= {hit_start[PN_W-1:0], PG_SHIFT'(0)};
            res_ok    <= 1'b1;
            rd_word   <= WW'(hit_start >> POS_W);
            last_word <= WW'((hit_end - PG_W'(1)) >> POS_W);
            ev_valid  <= 1'b0;
            state     <= ST_MARK;
          end else if (ev_valid && ev_word == last_word) begin
            ev_valid <= 1'b0;
            state    <= ST_RESP;
          end else begin
            ev_valid <= (rd_word <= last_word);
            rd_word  <= rd_word + WW'(1);
            if (ev_valid) begin
              if (scan.any_used) begin
                carry <= LEN_W'(POS_W'(WORD_W - 1) - scan.last_h);
                start <= base + PG_W'(scan.last_h) + PG_W'(1);
              end else begin
                carry <= carry + LEN_W'(WORD_W);
              end
            end
          end
        end
        ST_MARK: begin
          ev_word <= rd_word;
          rd_word <= rd_word + WW'(1);
          if (ev_valid && ev_word == last_word) begin
            ev_valid <= 1'b0;
            state    <= ST_RESP;
          end else begin
            ev_valid <= (rd_word <= last_word);
          end
        end
        ST_RESP: begin
          if (out_load) begin
            grant_addr <= res_addr;
            ok         <= res_ok;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
